// ===== design/cartridge_bank_mapper_macros.svh =====
// assertion macros shared by the bank mapper checks
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// clocked check, off while reset is asserted
`define CBM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bank mapper check failed");

// clocked check that also holds during reset
`define CBM_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("bank mapper check failed");

`endif

// ===== design/cbm_pkg.sv =====
// shared types and constants for the cartridge bank mapper
package cbm_pkg;

	// width of the mapped rom bank index
	localparam int ROM_BANK_BITS = 7;

	// target region codes
	typedef enum logic [1:0] {
		REGION_ROM      = 2'd0,
		REGION_EXT_RAM  = 2'd1,
		REGION_INTERNAL = 2'd2,
		REGION_REJECTED = 2'd3
	} region_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ROM_BANK_MASK       = 2'd0,
		CFG_UPPER_ROM_BANK_MASK = 2'd1,
		CFG_RAM_BANK_MASK       = 2'd2,
		CFG_RAM_PRESENT         = 2'd3
	} cfg_index_t;

	// bus access codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// ram enable key in the low nibble
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

endpackage

// ===== design/cartridge_bank_mapper.sv =====
// cartridge bank mapper: classifies cpu bus requests and maps rom and ram banks
//
// Input channel s_axis: one cpu bus request per transfer. tdata carries the
// address and the write byte, tuser the access kind (read or write).
// Output channel m_axis: one result per request, in order. tuser carries the
// target region, tdata the physical offset and the write strobe.
// The config port (cfg_we, cfg_index, cfg_data) loads the rom and ram bank
// masks and the ram present flag; the user must write it only while the
// block is idle, which the block does not enforce. A request is captured in
// the input register; the region decode, bank register update and offset
// build then feed the result register. A request can be accepted every
// cycle unless stalled; the bank registers are updated as a request leaves
// the input stage, so the request behind it already sees the new mapping.
// Reset clears the control registers, the masks and both stage valids; the
// switchable rom window starts at bank 1.
// When the receiver stalls, the result register holds and the input stage
// fills; s_axis_tready drops only while both are occupied and stalled.
module cartridge_bank_mapper
	import cbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	// request input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // address [15:0], data [23:16]
	input  logic        s_axis_tuser,   // op
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // phys_addr [20:0], mem_write [21], zero [23:22]
	output logic [1:0]  m_axis_tuser    // region
);

	// configuration registers
	logic [4:0] rom_bank_mask_q;
	logic [1:0] upper_rom_bank_mask_q;
	logic [1:0] ram_bank_mask_q;
	logic       ram_present_q;

	// controller state
	logic                     ram_enabled_q;
	logic [4:0]               primary_bank_q;
	logic [1:0]               secondary_bank_q;
	logic                     advanced_mode_q;
	logic [ROM_BANK_BITS-1:0] low_window_bank_q;
	logic [ROM_BANK_BITS-1:0] high_window_bank_q;
	logic [1:0]               ram_window_bank_q;

	// input stage
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;

	// result stage
	logic        valid_s2;
	region_t     region_s2;
	logic [20:0] phys_addr_s2;
	logic        mem_write_s2;

	logic advance;

	// next values from the decode
	region_t                  region_d;
	logic [20:0]              phys_addr_d;
	logic                     mem_write_d;
	logic                     ram_enabled_d;
	logic [4:0]               primary_bank_d;
	logic [1:0]               secondary_bank_d;
	logic                     advanced_mode_d;
	logic                     remap_rom;
	logic                     remap_ram;
	logic [4:0]               rom_sel;
	logic [6:0]               rom_upper;
	logic [6:0]               high_full;
	logic [6:0]               low_full;
	logic [1:0]               ram_bank_d;
	logic [ROM_BANK_BITS-1:0] rom_bank;

	// handshake
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_mask_q       <= '0;
			upper_rom_bank_mask_q <= '0;
			ram_bank_mask_q       <= '0;
			ram_present_q         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROM_BANK_MASK:       rom_bank_mask_q       <= cfg_data;
				CFG_UPPER_ROM_BANK_MASK: upper_rom_bank_mask_q <= cfg_data[1:0];
				CFG_RAM_BANK_MASK:       ram_bank_mask_q       <= cfg_data[1:0];
				CFG_RAM_PRESENT:         ram_present_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// decode and bank register update
	always_comb begin
		region_d         = REGION_INTERNAL;
		phys_addr_d      = {5'd0, address_s1};
		mem_write_d      = 1'b0;
		ram_enabled_d    = ram_enabled_q;
		primary_bank_d   = primary_bank_q;
		secondary_bank_d = secondary_bank_q;
		advanced_mode_d  = advanced_mode_q;
		remap_rom        = 1'b0;
		remap_ram        = 1'b0;
		rom_bank         = address_s1[14] ? high_window_bank_q : low_window_bank_q;

		if (!address_s1[15]) begin
			region_d = REGION_ROM;
			if (op_s1 == OP_WRITE) begin
				case (address_s1[14:13])
					2'd0: ram_enabled_d = (data_s1[3:0] == RAM_ENABLE_KEY);
					2'd1: begin
						primary_bank_d = data_s1[4:0];
						remap_rom      = 1'b1;
					end
					2'd2: begin
						secondary_bank_d = data_s1[1:0];
						remap_rom        = 1'b1;
						remap_ram        = ram_present_q;
					end
					default: begin
						advanced_mode_d = data_s1[0];
						remap_rom       = 1'b1;
						remap_ram       = ram_present_q;
					end
				endcase
			end else begin
				phys_addr_d = 21'({rom_bank, address_s1[13:0]});
			end
		end else if (address_s1[15:13] == 3'b101) begin
			region_d    = REGION_EXT_RAM;
			phys_addr_d = {6'd0, ram_window_bank_q, address_s1[12:0]};
			mem_write_d = (op_s1 == OP_WRITE) && ram_enabled_q;
		end else if ((op_s1 == OP_WRITE) && (address_s1 >= 16'hFEA0)
				&& (address_s1 < 16'hFF00)) begin
			region_d = REGION_REJECTED;
		end else begin
			mem_write_d = op_s1;
		end

		// mapped bank indices from the updated registers
		rom_sel    = (primary_bank_d == 5'd0) ? 5'd1 : primary_bank_d;
		rom_upper  = {secondary_bank_d & upper_rom_bank_mask_q, 5'd0};
		high_full  = {2'd0, rom_sel & rom_bank_mask_q} | rom_upper;
		low_full   = advanced_mode_d ? (rom_upper & 7'b1100000) : 7'd0;
		ram_bank_d = advanced_mode_d ? (secondary_bank_d & ram_bank_mask_q) : 2'd0;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1      <= s_axis_tuser;
			address_s1 <= s_axis_tdata[15:0];
			data_s1    <= s_axis_tdata[23:16];
		end
	end

	// controller state, updated as a request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q      <= 1'b0;
			primary_bank_q     <= '0;
			secondary_bank_q   <= '0;
			advanced_mode_q    <= 1'b0;
			low_window_bank_q  <= '0;
			high_window_bank_q <= ROM_BANK_BITS'(1);
			ram_window_bank_q  <= '0;
		end else if (advance) begin
			ram_enabled_q    <= ram_enabled_d;
			primary_bank_q   <= primary_bank_d;
			secondary_bank_q <= secondary_bank_d;
			advanced_mode_q  <= advanced_mode_d;
			if (remap_rom) begin
				high_window_bank_q <= high_full[ROM_BANK_BITS-1:0];
				low_window_bank_q  <= low_full[ROM_BANK_BITS-1:0];
			end
			if (remap_ram) begin
				ram_window_bank_q <= ram_bank_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			region_s2    <= region_d;
			phys_addr_s2 <= phys_addr_d;
			mem_write_s2 <= mem_write_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, mem_write_s2, phys_addr_s2};
	assign m_axis_tuser  = region_s2;

endmodule

// ===== design/cbm_checker.sv =====
// port-level checks for the cartridge bank mapper, bound to the top level
`include "cartridge_bank_mapper_macros.svh"

module cbm_checker
	import cbm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result holds its payload
	`CBM_ASSERT(stall_holds_result, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// control writes and rejected writes never strobe a store
	`CBM_ASSERT(no_strobe_rom_or_rejected, m_axis_tvalid && (m_axis_tuser == REGION_ROM || m_axis_tuser == REGION_REJECTED) |-> !m_axis_tdata[21])

	// ram offsets stay inside four 8 KiB banks
	`CBM_ASSERT(ram_offset_range, m_axis_tvalid && m_axis_tuser == REGION_EXT_RAM |-> m_axis_tdata[20:15] == 6'd0)

	// pass-through and rejected results carry the bus address unchanged in width
	`CBM_ASSERT(passthrough_width, m_axis_tvalid && (m_axis_tuser == REGION_INTERNAL || m_axis_tuser == REGION_REJECTED) |-> m_axis_tdata[20:16] == 5'd0)

	// no result is presented as reset is released
	`CBM_ASSERT_ALWAYS(idle_after_reset, $rose(arst_n) |-> !m_axis_tvalid)

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
